FILE: sv/hlt_pkg.sv
// Package: shared types and constants for the heartbeat liveness table.
`timescale 1ns / 1ps
`default_nettype none

package hlt_pkg;

    localparam int MAX_ENTRIES_DEF = 8;
    localparam int ID_W            = 22;
    localparam int TIME_W          = 32;
    localparam int TIMEOUT_W       = 8;
    localparam int MASK_W          = 8;
    localparam int COUNT_W         = 4;
    localparam int CFG_INDEX_W     = 4;
    localparam int CFG_DATA_W      = 32;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd3;
    localparam logic [ID_W-1:0]      OWN_ID_RESET  = '0;
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIMEOUT = 4'd0,
        CFG_OWN_ID  = 4'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_REGISTER  = 2'd0,
        MODE_HEARTBEAT = 2'd1,
        MODE_CHECK     = 2'd2
    } mode_t;

    // Item token walking down the cell chain, with results gathered on the way.
    typedef struct packed {
        logic                vld;
        mode_t               mode;
        logic [ID_W-1:0]     client_id;
        logic [TIME_W-1:0]   time_value;
        logic                claim;
        logic                accepted;
        logic [MASK_W-1:0]   alive_mask;
        logic [MASK_W-1:0]   newly_dead_mask;
        logic [MASK_W-1:0]   newly_alive_mask;
        logic [COUNT_W-1:0]  client_count;
    } token_t;

endpackage

`default_nettype wire

FILE: sv/hlt_ifs.sv
// Interfaces: item, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface hlt_item_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [hlt_pkg::ID_W-1:0]    client_id;
    logic [hlt_pkg::TIME_W-1:0]  time_value;

    modport source (output valid, mode, client_id, time_value, input ready);
    modport sink   (input valid, mode, client_id, time_value, output ready);
endinterface

interface hlt_result_if;
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic [hlt_pkg::MASK_W-1:0]   alive_mask;
    logic [hlt_pkg::MASK_W-1:0]   newly_dead_mask;
    logic [hlt_pkg::MASK_W-1:0]   newly_alive_mask;
    logic [hlt_pkg::COUNT_W-1:0]  client_count;

    modport source (output valid, accepted, alive_mask, newly_dead_mask,
                    newly_alive_mask, client_count, input ready);
    modport sink   (input valid, accepted, alive_mask, newly_dead_mask,
                    newly_alive_mask, client_count, output ready);
endinterface

interface hlt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hlt_pkg::CFG_INDEX_W-1:0]  index;
    logic [hlt_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/hlt_cell.sv
// One table slot: holds a client entry and updates the passing token.
`timescale 1ns / 1ps
`default_nettype none

module hlt_cell #(
    parameter int SLOT_INDEX = 0
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              adv,
    input  wire logic [hlt_pkg::TIMEOUT_W-1:0]     timeout,
    input  wire hlt_pkg::token_t                   tok_in,
    output      hlt_pkg::token_t                   tok_out
);

    localparam int MW = hlt_pkg::MASK_W;
    localparam logic [MW-1:0] SLOT_BIT = (SLOT_INDEX < MW) ? (MW'(1) << SLOT_INDEX) : '0;

    logic [hlt_pkg::ID_W-1:0]    id_reg, id_next;
    logic [hlt_pkg::TIME_W-1:0]  time_reg, time_next;
    logic                        valid_reg, valid_next;
    logic                        alive_reg, alive_next;
    logic [hlt_pkg::TIME_W-1:0]  gap;
    hlt_pkg::token_t             tok_reg, tok_next;

    always_comb
    begin
        tok_next   = tok_in;
        id_next    = id_reg;
        time_next  = time_reg;
        valid_next = valid_reg;
        alive_next = alive_reg;
        gap        = tok_in.time_value - time_reg;
        if (tok_in.vld)
        begin
            case (tok_in.mode)
                hlt_pkg::MODE_REGISTER:
                begin
                    // slots fill in order, so the first free cell is the next slot
                    if (!tok_in.claim && !valid_reg)
                    begin
                        tok_next.claim    = 1'b1;
                        tok_next.accepted = 1'b1;
                        valid_next        = 1'b1;
                        alive_next        = 1'b1;
                        id_next           = tok_in.client_id;
                        time_next         = tok_in.time_value;
                    end
                end
                hlt_pkg::MODE_HEARTBEAT:
                begin
                    if (!tok_in.claim && valid_reg && id_reg == tok_in.client_id)
                    begin
                        tok_next.claim    = 1'b1;
                        tok_next.accepted = 1'b1;
                        time_next         = tok_in.time_value;
                        if (!alive_reg)
                        begin
                            alive_next = 1'b1;
                            tok_next.newly_alive_mask = tok_in.newly_alive_mask | SLOT_BIT;
                        end
                    end
                end
                hlt_pkg::MODE_CHECK:
                begin
                    if (valid_reg)
                    begin
                        if (gap > {{(hlt_pkg::TIME_W-hlt_pkg::TIMEOUT_W){1'b0}}, timeout})
                        begin
                            if (alive_reg)
                            begin
                                alive_next = 1'b0;
                                tok_next.newly_dead_mask = tok_in.newly_dead_mask | SLOT_BIT;
                            end
                        end
                        else if (!alive_reg)
                        begin
                            alive_next = 1'b1;
                            tok_next.newly_alive_mask = tok_in.newly_alive_mask | SLOT_BIT;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (valid_next && alive_next)
        begin
            tok_next.alive_mask = tok_in.alive_mask | SLOT_BIT;
        end
        if (valid_next && tok_in.client_count != hlt_pkg::COUNT_MAX)
        begin
            tok_next.client_count = tok_in.client_count + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            alive_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
            if (tok_in.vld)
            begin
                valid_reg <= valid_next;
                alive_reg <= alive_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tok_in.vld)
        begin
            id_reg   <= id_next;
            time_reg <= time_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

FILE: sv/heartbeat_liveness_table.sv
// Top level: heartbeat liveness table built as a chain of slot cells.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------------
//  cfg      | in  | valid / ready | index, data (timeout_seconds, own_id)
//  item     | in  | valid / ready | mode, client_id, time_value
//  result   | out | valid / ready | accepted, alive_mask, newly_dead_mask,
//           |     |               | newly_alive_mask, client_count
//
// An item walks the cell chain one slot per cycle, one item accepted per cycle, while
// the result is not stalled. The last cell's token register is the result register.
// A stalled result freezes the whole chain; item.ready = !result.valid || result.ready.
// Reset clears slot valid/alive flags at once; no clearing pass. cfg.ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module heartbeat_liveness_table #(
    parameter int MAX_ENTRIES = hlt_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    hlt_cfg_if.sink       cfg,
    hlt_item_if.sink      item,
    hlt_result_if.source  result
);

    logic [hlt_pkg::TIMEOUT_W-1:0]  timeout_reg;
    logic [hlt_pkg::ID_W-1:0]       own_id_reg;
    hlt_pkg::token_t                item_tok;
    hlt_pkg::token_t                tok [0:MAX_ENTRIES];
    logic                           adv;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= hlt_pkg::TIMEOUT_RESET;
            own_id_reg  <= hlt_pkg::OWN_ID_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (hlt_pkg::cfg_index_t'(cfg.index))
                hlt_pkg::CFG_TIMEOUT: timeout_reg <= cfg.data[hlt_pkg::TIMEOUT_W-1:0];
                hlt_pkg::CFG_OWN_ID:  own_id_reg  <= cfg.data[hlt_pkg::ID_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign adv        = !tok[MAX_ENTRIES].vld || result.ready;
    assign item.ready = adv;

    always_comb
    begin
        item_tok                = '0;
        item_tok.vld            = item.valid;
        item_tok.mode           = hlt_pkg::mode_t'(item.mode);
        item_tok.client_id      = item.client_id;
        item_tok.time_value     = item.time_value;
        // own id never registers: pre-claim so no cell takes it
        item_tok.claim          = (item.mode == hlt_pkg::MODE_REGISTER)
                                  && (item.client_id == own_id_reg);
        item_tok.accepted       = (item.mode == hlt_pkg::MODE_CHECK);
    end

    assign tok[0] = item_tok;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        hlt_cell #(
            .SLOT_INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .timeout (timeout_reg),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    assign result.valid            = tok[MAX_ENTRIES].vld;
    assign result.accepted         = tok[MAX_ENTRIES].accepted;
    assign result.alive_mask       = tok[MAX_ENTRIES].alive_mask;
    assign result.newly_dead_mask  = tok[MAX_ENTRIES].newly_dead_mask;
    assign result.newly_alive_mask = tok[MAX_ENTRIES].newly_alive_mask;
    assign result.client_count     = tok[MAX_ENTRIES].client_count;

endmodule

`default_nettype wire

FILE: sv/hlt_checker.sv
// Checker: port-level assertions for the heartbeat liveness table, with bind.
`timescale 1ns / 1ps
`default_nettype none

module hlt_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_ready,
    input  wire logic                           res_valid,
    input  wire logic                           res_ready,
    input  wire logic                           res_accepted,
    input  wire logic [hlt_pkg::MASK_W-1:0]     res_alive_mask,
    input  wire logic [hlt_pkg::MASK_W-1:0]     res_newly_dead_mask,
    input  wire logic [hlt_pkg::MASK_W-1:0]     res_newly_alive_mask,
    input  wire logic [hlt_pkg::COUNT_W-1:0]    res_client_count
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable({res_accepted, res_alive_mask,
            res_newly_dead_mask, res_newly_alive_mask, res_client_count}))
        else $error("result payload changed while stalled");

    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> item_ready)
        else $error("item channel stalled with no pending result");

    a_dead_not_alive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_newly_dead_mask & res_alive_mask) == '0)
                   && ((res_newly_alive_mask & ~res_alive_mask) == '0))
        else $error("newly dead/alive masks disagree with alive mask");

    a_change_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ((res_newly_dead_mask | res_newly_alive_mask) != '0) |-> res_accepted)
        else $error("slot changed state on an item that was not accepted");

endmodule

bind heartbeat_liveness_table hlt_checker u_hlt_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .item_ready           (item.ready),
    .res_valid            (result.valid),
    .res_ready            (result.ready),
    .res_accepted         (result.accepted),
    .res_alive_mask       (result.alive_mask),
    .res_newly_dead_mask  (result.newly_dead_mask),
    .res_newly_alive_mask (result.newly_alive_mask),
    .res_client_count     (result.client_count)
);

`default_nettype wire
